// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dmwb_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwb_pkg
// Shared types and constants of the direct-mapped write-back cache controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmwb_pkg;

	localparam int unsigned WORD_W         = 32;
	localparam int unsigned ADDR_W         = 32;
	localparam int unsigned OFFSET_W       = 4;              // byte offset inside a block
	localparam int unsigned BLK_W          = ADDR_W - OFFSET_W;
	localparam int unsigned WORDS          = 4;
	localparam int unsigned WOFF_W         = 2;
	localparam int unsigned WOFF_LSB       = 2;
	localparam int unsigned LINE_COUNT_DEF = 1024;

	// ctrl_state codes seen on the result channel
	localparam logic [1:0] CODE_IDLE      = 2'd0;
	localparam logic [1:0] CODE_COMPARE   = 2'd1;
	localparam logic [1:0] CODE_WRITEBACK = 2'd2;
	localparam logic [1:0] CODE_ALLOCATE  = 2'd3;

	typedef struct packed {
		logic                cpu_valid;
		logic                func;
		logic [ADDR_W-1:0]   cpu_address;
		logic [WORD_W-1:0]   cpu_write_data;
		logic                mem_ready;
		logic [WORD_W-1:0]   mem_read_word0;
		logic [WORD_W-1:0]   mem_read_word1;
		logic [WORD_W-1:0]   mem_read_word2;
		logic [WORD_W-1:0]   mem_read_word3;
	} req_t;

	typedef struct packed {
		logic                cpu_ready;
		logic [WORD_W-1:0]   cpu_read_data;
		logic                mem_valid;
		logic                mem_write;
		logic [ADDR_W-1:0]   mem_address;
		logic [WORD_W-1:0]   mem_write_word0;
		logic [WORD_W-1:0]   mem_write_word1;
		logic [WORD_W-1:0]   mem_write_word2;
		logic [WORD_W-1:0]   mem_write_word3;
		logic [1:0]          ctrl_state;
	} rsp_t;

	// One line's bookkeeping; the full block number stands in for the tag.
	typedef struct packed {
		logic               valid;
		logic               dirty;
		logic [BLK_W-1:0]   blk;
	} meta_t;

	// Controller to datapath
	typedef struct packed {
		logic        take;
		logic        clear_wr;
		logic        read_en;
		logic        latch;
		logic        hit_load;
		logic        hit_store;
		logic        wb_start;
		logic        wb_wait;
		logic        wb_done;
		logic        alloc_start;
		logic        alloc_wait;
		logic        alloc_fill;
		logic [1:0]  next_code;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;
		logic victim_dirty;
		logic store;
		logic idx_done;
		logic clear_last;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/dmwb_ram.sv =====
// ----------------------------------------------------------------------------
// dmwb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmwb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmwb_lidx.sv =====
// ----------------------------------------------------------------------------
// dmwb_lidx
// Line index unit: block number modulo the line count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmwb_lidx #(
	parameter int unsigned LINE_COUNT = dmwb_pkg::LINE_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dmwb_pkg::BLK_W-1:0]    dividend,
	output logic                               done,
	output logic      [$clog2(LINE_COUNT)-1:0] idx
);
	import dmwb_pkg::*;

	localparam int unsigned IDX_W = $clog2(LINE_COUNT);
	localparam bit IS_POW2 = (LINE_COUNT & (LINE_COUNT - 1)) == 0;

	if (IS_POW2) begin : g_mask
		// power of two: take the low bits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				idx  <= '0;
				done <= 1'b0;
			end else begin
				done <= start;
				if (start) begin
					idx <= dividend[IDX_W-1:0];
				end
			end
		end
	end else begin : g_recip
		// Estimate the quotient with a reciprocal multiply (low by at most one),
		// multiply back and subtract, then correct with one compare and subtract.
		localparam logic [BLK_W-1:0] RECIP   = BLK_W'((64'd1 << BLK_W) / LINE_COUNT);
		localparam logic [BLK_W-1:0] DIVISOR = BLK_W'(LINE_COUNT);

		logic [BLK_W-1:0]   num_s1;
		logic [2*BLK_W-1:0] prod_s1;
		logic               vld_s1;
		logic [BLK_W-1:0]   rem_s2;
		logic               vld_s2;
		logic [2*BLK_W-1:0] back;

		assign back = prod_s1[2*BLK_W-1:BLK_W] * DIVISOR;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				idx     <= '0;
				done    <= 1'b0;
				num_s1  <= '0;
				prod_s1 <= '0;
				vld_s1  <= 1'b0;
				rem_s2  <= '0;
				vld_s2  <= 1'b0;
			end else begin
				vld_s1 <= start;
				vld_s2 <= vld_s1;
				done   <= vld_s2;
				if (start) begin
					num_s1  <= dividend;
					prod_s1 <= dividend * RECIP;
				end
				if (vld_s1) begin
					rem_s2 <= num_s1 - back[BLK_W-1:0];
				end
				if (vld_s2) begin
					idx <= (rem_s2 >= DIVISOR) ? IDX_W'(rem_s2 - DIVISOR) : rem_s2[IDX_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmwb_dp.sv =====
// ----------------------------------------------------------------------------
// dmwb_dp
// Datapath: held request, line index, line RAMs, transfer address, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmwb_dp #(
	parameter int unsigned LINE_COUNT = dmwb_pkg::LINE_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dmwb_pkg::req_t    req,
	input  wire dmwb_pkg::cmd_t    cmd,
	output dmwb_pkg::status_t      st,
	output dmwb_pkg::rsp_t         rsp
);
	import dmwb_pkg::*;

	localparam int unsigned IDX_W = $clog2(LINE_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_COUNT - 1);

	logic [ADDR_W-1:0]  held_addr_q;
	logic               held_kind_q;
	logic [WORD_W-1:0]  held_store_q;
	logic [ADDR_W-1:0]  transfer_q;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [IDX_W-1:0]   held_idx;
	logic               idx_done;

	logic [BLK_W-1:0]   held_blk;
	logic [ADDR_W-1:0]  held_blk_addr;
	logic [ADDR_W-1:0]  victim_addr;
	logic [WOFF_W-1:0]  word_off;

	logic                    meta_we;
	logic [IDX_W-1:0]        meta_waddr;
	meta_t                   meta_wdata;
	logic [$bits(meta_t)-1:0] meta_rdata;
	meta_t                   rd_meta;

	logic [WORDS-1:0]   word_we;
	logic [WORD_W-1:0]  fill_word [WORDS];
	logic [WORD_W-1:0]  rd_word   [WORDS];
	rsp_t               rsp_d;

	assign held_blk      = held_addr_q[ADDR_W-1:OFFSET_W];
	assign held_blk_addr = {held_blk, OFFSET_W'(0)};
	assign word_off      = held_addr_q[WOFF_LSB +: WOFF_W];
	assign rd_meta       = meta_t'(meta_rdata);
	assign victim_addr   = {rd_meta.blk, OFFSET_W'(0)};

	assign fill_word[0] = req.mem_read_word0;
	assign fill_word[1] = req.mem_read_word1;
	assign fill_word[2] = req.mem_read_word2;
	assign fill_word[3] = req.mem_read_word3;

	assign st.hit          = rd_meta.valid && (rd_meta.blk == held_blk);
	assign st.victim_dirty = rd_meta.valid && rd_meta.dirty;
	assign st.store        = held_kind_q;
	assign st.idx_done     = idx_done;
	assign st.clear_last   = (clr_idx_q == LAST_IDX);

	dmwb_lidx #(
		.LINE_COUNT (LINE_COUNT)
	) u_lidx (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.latch),
		.dividend (req.cpu_address[ADDR_W-1:OFFSET_W]),
		.done     (idx_done),
		.idx      (held_idx)
	);

	// held request and transfer address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_addr_q  <= '0;
			held_kind_q  <= 1'b0;
			held_store_q <= '0;
			transfer_q   <= '0;
			clr_idx_q    <= '0;
		end else begin
			if (cmd.latch) begin
				held_addr_q  <= req.cpu_address;
				held_kind_q  <= req.func;
				held_store_q <= req.cpu_write_data;
			end
			if (cmd.wb_start) begin
				transfer_q <= victim_addr;
			end else if (cmd.alloc_start || cmd.wb_done) begin
				transfer_q <= held_blk_addr;
			end
			if (cmd.clear_wr) begin
				clr_idx_q <= st.clear_last ? '0 : clr_idx_q + IDX_W'(1);
			end
		end
	end

	// line bookkeeping update
	always_comb begin
		meta_we    = cmd.clear_wr | cmd.hit_store | cmd.wb_done | cmd.alloc_fill;
		meta_waddr = cmd.clear_wr ? clr_idx_q : held_idx;
		meta_wdata = '0;
		if (cmd.hit_store) begin
			meta_wdata.valid = 1'b1;
			meta_wdata.dirty = 1'b1;
			meta_wdata.blk   = rd_meta.blk;
		end else if (cmd.wb_done) begin
			meta_wdata.valid = rd_meta.valid;
			meta_wdata.blk   = rd_meta.blk;
		end else if (cmd.alloc_fill) begin
			meta_wdata.valid = 1'b1;
			meta_wdata.blk   = held_blk;
		end
	end

	dmwb_ram #(
		.WIDTH ($bits(meta_t)),
		.DEPTH (LINE_COUNT)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (cmd.read_en),
		.raddr (held_idx),
		.rdata (meta_rdata)
	);

	for (genvar gi = 0; gi < WORDS; gi++) begin : g_bank
		assign word_we[gi] = cmd.alloc_fill |
			(cmd.hit_store && (word_off == WOFF_W'(gi)));

		dmwb_ram #(
			.WIDTH (WORD_W),
			.DEPTH (LINE_COUNT)
		) u_word_ram (
			.clk   (clk),
			.we    (word_we[gi]),
			.waddr (held_idx),
			.wdata (cmd.alloc_fill ? fill_word[gi] : held_store_q),
			.re    (cmd.read_en),
			.raddr (held_idx),
			.rdata (rd_word[gi])
		);
	end

	// result of this transaction
	always_comb begin
		rsp_d           = '0;
		rsp_d.cpu_ready = cmd.hit_load | cmd.hit_store;
		if (cmd.hit_load) begin
			rsp_d.cpu_read_data = rd_word[word_off];
		end
		rsp_d.mem_valid = cmd.wb_start | cmd.wb_wait | cmd.wb_done |
			cmd.alloc_start | cmd.alloc_wait | cmd.alloc_fill;
		rsp_d.mem_write = cmd.wb_start | cmd.wb_wait;
		if (cmd.wb_start) begin
			rsp_d.mem_address = victim_addr;
		end else if (cmd.alloc_start || cmd.wb_done) begin
			rsp_d.mem_address = held_blk_addr;
		end else if (cmd.wb_wait || cmd.alloc_wait || cmd.alloc_fill) begin
			rsp_d.mem_address = transfer_q;
		end
		if (rsp_d.mem_write) begin
			rsp_d.mem_write_word0 = rd_word[0];
			rsp_d.mem_write_word1 = rd_word[1];
			rsp_d.mem_write_word2 = rd_word[2];
			rsp_d.mem_write_word3 = rd_word[3];
		end
		rsp_d.ctrl_state = cmd.next_code;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rsp <= rsp_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dmwb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmwb_ctrl
// Controller: cache state machine, access sequencer and channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmwb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic               cpu_valid,
	input  wire logic               mem_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	input  wire dmwb_pkg::status_t  st,
	output dmwb_pkg::cmd_t          cmd
);
	import dmwb_pkg::*;

	typedef enum logic [3:0] {
		CS_IDLE      = 4'b0001,
		CS_COMPARE   = 4'b0010,
		CS_WRITEBACK = 4'b0100,
		CS_ALLOCATE  = 4'b1000
	} cstate_t;

	typedef enum logic [3:0] {
		PH_CLEAR  = 4'b0001,
		PH_READ   = 4'b0010,
		PH_LOOKUP = 4'b0100,
		PH_INDEX  = 4'b1000
	} phase_t;

	cstate_t cs_q, cs_d;
	phase_t  ph_q, ph_d;
	logic    rsp_valid_q;
	logic    take;

	function automatic logic [1:0] code_of(cstate_t s);
		logic [1:0] c;
		unique case (s)
			CS_IDLE:      c = CODE_IDLE;
			CS_COMPARE:   c = CODE_COMPARE;
			CS_WRITEBACK: c = CODE_WRITEBACK;
			CS_ALLOCATE:  c = CODE_ALLOCATE;
			default:      c = CODE_IDLE;
		endcase
		return c;
	endfunction

	assign req_ready = (ph_q == PH_LOOKUP) && (!rsp_valid_q || rsp_ready);
	assign take      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.take = take;
		cs_d     = cs_q;
		ph_d     = ph_q;
		unique case (ph_q)
			PH_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (st.clear_last) begin
					ph_d = PH_READ;
				end
			end
			PH_READ: begin
				cmd.read_en = 1'b1;
				ph_d        = PH_LOOKUP;
			end
			PH_LOOKUP: begin
				if (take) begin
					unique case (cs_q)
						CS_IDLE: begin
							if (cpu_valid) begin
								cmd.latch = 1'b1;
								cs_d      = CS_COMPARE;
							end
						end
						CS_COMPARE: begin
							if (st.hit) begin
								cmd.hit_load  = !st.store;
								cmd.hit_store = st.store;
								cs_d          = CS_IDLE;
							end else if (st.victim_dirty) begin
								cmd.wb_start = 1'b1;
								cs_d         = CS_WRITEBACK;
							end else begin
								cmd.alloc_start = 1'b1;
								cs_d            = CS_ALLOCATE;
							end
						end
						CS_WRITEBACK: begin
							if (mem_ready) begin
								cmd.wb_done = 1'b1;
								cs_d        = CS_ALLOCATE;
							end else begin
								cmd.wb_wait = 1'b1;
							end
						end
						CS_ALLOCATE: begin
							if (mem_ready) begin
								cmd.alloc_fill = 1'b1;
								cs_d           = CS_COMPARE;
							end else begin
								cmd.alloc_wait = 1'b1;
							end
						end
						default: cs_d = CS_IDLE;
					endcase
					// re-read the line after any step that may have touched it
					if (cmd.latch) begin
						ph_d = PH_INDEX;
					end else if (cs_q != CS_IDLE) begin
						ph_d = PH_READ;
					end
				end
			end
			PH_INDEX: begin
				if (st.idx_done) begin
					ph_d = PH_READ;
				end
			end
			default: ph_d = PH_CLEAR;
		endcase
		cmd.next_code = code_of(cs_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q        <= CS_IDLE;
			ph_q        <= PH_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			cs_q <= cs_d;
			ph_q <= ph_d;
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_writeback_cache_ctrl.sv =====
// Direct-mapped, write-back, write-allocate cache controller. Each transaction on
// the req channel is one tick of the controller (idle, compare, writeback,
// allocate) and yields exactly one transaction on the rsp channel. After reset
// the block clears the line valid and dirty bits, one line per cycle, then
// reads the line, and takes no request in that time. A transaction in idle
// with no CPU request is taken every cycle while the rsp side does not stall,
// except that the first one after a completed request waits for the line
// re-read. A compare, writeback or allocate transaction takes the line RAM
// read and then the decision, as the tag and data RAMs have a registered read
// port. A transaction that latches a new CPU request is followed by the line
// index computation (the low bits when LINE_COUNT is a power of two, otherwise
// reciprocal multiply, multiply back and subtract, correcting subtract), then
// the line read. A finished result waits in an output register, so a stalled
// rsp side holds off the next request only once that register is full.
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_ctrl
// Top level: controller and datapath of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module direct_mapped_writeback_cache_ctrl #(
	parameter int unsigned LINE_COUNT = dmwb_pkg::LINE_COUNT_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire dmwb_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output dmwb_pkg::rsp_t       rsp
);
	import dmwb_pkg::*;

	cmd_t    cmd;
	status_t st;
	logic    req_take;
	logic    dirty_miss;

	assign req_take   = req_valid && req_ready;
	assign dirty_miss = st.victim_dirty && !st.hit;

	// Controller: holds the cache state, sequences RAM reads and the index unit,
	// and owns both handshakes.
	dmwb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cpu_valid (req.cpu_valid),
		.mem_ready (req.mem_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: held request, line RAMs, transfer address and result register.
	dmwb_dp #(
		.LINE_COUNT (LINE_COUNT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

	// Every taken transaction leaves a result behind.
	`ASSERT_NEXT(a_take_gives_rsp, clk, arst_n, req_take, rsp_valid, "taken without result")
	// Writeback only starts for a dirty line that missed.
	`ASSERT_SAME(a_wb_on_dirty_miss, clk, arst_n, cmd.wb_start, dirty_miss, "wb without dirty miss")
	// A fill must be re-read before the next decision.
	`ASSERT_NEXT(a_fill_rereads, clk, arst_n, cmd.alloc_fill, !req_ready, "taken after fill")
	// Hold off requests while the clearing pass runs.
	`ASSERT_SAME(a_clear_blocks, clk, arst_n, cmd.clear_wr, !req_ready, "taken while clearing")

endmodule

`default_nettype wire
